// ===== hw/rtl/tnrop_pkg.sv =====
// Shared constants, codes and types for the telnet receive option parser.
package tnrop_pkg;

  localparam logic [7:0] B_IAC  = 8'd255;
  localparam logic [7:0] B_DONT = 8'd254;
  localparam logic [7:0] B_DO   = 8'd253;
  localparam logic [7:0] B_WONT = 8'd252;
  localparam logic [7:0] B_WILL = 8'd251;
  localparam logic [7:0] B_SB   = 8'd250;
  localparam logic [7:0] B_SE   = 8'd240;

  localparam logic [7:0] OPTION_ECHO = 8'd1;
  localparam logic [7:0] OPT_SGA     = 8'd3;
  localparam logic [7:0] OPT_TT      = 8'd24;
  localparam logic [7:0] TT_IS       = 8'd0;
  localparam logic [7:0] TT_SEND     = 8'd1;

  localparam logic [1:0] VERB_WILL = 2'd0;
  localparam logic [1:0] VERB_DO   = 2'd2;

  localparam logic [3:0] UNKNOWN_LEN = 4'd7;

  typedef enum logic [2:0] {
    REG_TERMTYPE_ALLOWED    = 3'd0,
    REG_ECHO_ALLOWED        = 3'd1,
    REG_SUPPRESS_GA_ALLOWED = 3'd2,
    REG_TERM_NAME           = 3'd3,
    REG_TERM_NAME_LENGTH    = 3'd4
  } reg_index_t;

  typedef enum logic [6:0] {
    PH_DATA     = 7'b0000001,
    PH_IAC      = 7'b0000010,
    PH_OPT      = 7'b0000100,
    PH_SB_OPT   = 7'b0001000,
    PH_SB_CMD   = 7'b0010000,
    PH_SKIP     = 7'b0100000,
    PH_SKIP_IAC = 7'b1000000
  } phase_t;

  typedef enum logic [1:0] {
    K_NONE   = 2'd0,
    K_DATA   = 2'd1,
    K_REPLY3 = 2'd2,
    K_TTSEND = 2'd3
  } kind_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] b0;
    logic [7:0] b1;
    logic       echo;
  } desc_t;

  function automatic logic [7:0] unknown_char(input logic [2:0] i);
    logic [7:0] c;
    unique case (i)
      3'd0: c = 8'h75;
      3'd1: c = 8'h6e;
      3'd2: c = 8'h6b;
      3'd3: c = 8'h6e;
      3'd4: c = 8'h6f;
      3'd5: c = 8'h77;
      3'd6: c = 8'h6e;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

// ===== hw/rtl/telnet_receive_option_parser.sv =====
// Top level of the telnet receive option parser: configuration registers, parser and result stage.
// The first result of an accepted byte is registered and shows in the cycle after the byte is accepted.
// Throughput: one byte per cycle while each byte causes at most one result and out_tready is high.
// An option reply takes three beats and a terminal-type reply 7 to 14; input waits for the last.
// Reset (synchronous, rst_n low) returns to the plain data phase with all options off,
// the allowed flags set, the terminal name cleared and no result pending.
module telnet_receive_option_parser #(
  parameter int NAME_BYTES = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] rx_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [7:0] out_byte, [8] remote_echo, [15:9] zero
  output logic        out_tuser,  // [0] dest
  output logic        out_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data
);

  logic                    termtype_allowed_r;
  logic                    echo_allowed_r;
  logic                    sga_allowed_r;
  logic [NAME_BYTES*8-1:0] term_name_r;
  logic [3:0]              term_name_length_r;
  logic                    can_load;
  logic                    in_accept;
  tnrop_pkg::desc_t        desc;

  assign cfg_ready = 1'b1;
  assign in_tready = can_load;
  assign in_accept = in_tvalid && can_load;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      termtype_allowed_r <= 1'b1;
      echo_allowed_r     <= 1'b1;
      sga_allowed_r      <= 1'b1;
      term_name_r        <= '0;
      term_name_length_r <= 4'd0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        tnrop_pkg::REG_TERMTYPE_ALLOWED:    termtype_allowed_r <= cfg_data[0];
        tnrop_pkg::REG_ECHO_ALLOWED:        echo_allowed_r     <= cfg_data[0];
        tnrop_pkg::REG_SUPPRESS_GA_ALLOWED: sga_allowed_r      <= cfg_data[0];
        tnrop_pkg::REG_TERM_NAME:           term_name_r        <= cfg_data[NAME_BYTES*8-1:0];
        tnrop_pkg::REG_TERM_NAME_LENGTH:    term_name_length_r <= cfg_data[3:0];
        default: begin
        end
      endcase
    end
  end

  tnrop_parse u_parse (
    .clk                 (clk),
    .rst_n               (rst_n),
    .accept              (in_accept),
    .rx_byte             (in_tdata),
    .termtype_allowed    (termtype_allowed_r),
    .echo_allowed        (echo_allowed_r),
    .suppress_ga_allowed (sga_allowed_r),
    .desc                (desc)
  );

  tnrop_emit #(
    .NAME_BYTES (NAME_BYTES)
  ) u_emit (
    .clk              (clk),
    .rst_n            (rst_n),
    .load             (in_accept),
    .desc             (desc),
    .term_name        (term_name_r),
    .term_name_length (term_name_length_r),
    .can_load         (can_load),
    .out_tvalid       (out_tvalid),
    .out_tready       (out_tready),
    .out_tdata        (out_tdata),
    .out_tuser        (out_tuser),
    .out_tlast        (out_tlast)
  );

  // Bytes for the display always come one result per received byte.
  a_display_single : assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tlast)
    else $error("display byte not marked last");

  // Once echo is on it stays on between consecutive results.
  a_echo_sticky : assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && $past(out_tvalid) && $past(out_tdata[8]) |-> out_tdata[8])
    else $error("remote echo dropped");

  // A reply that starts right after a finished request opens with IAC.
  a_reply_starts_iac : assert property (@(posedge clk) disable iff (!rst_n)
    $past(out_tvalid && out_tready && out_tlast) && out_tvalid && out_tuser
    |-> out_tdata[7:0] == tnrop_pkg::B_IAC)
    else $error("reply does not start with IAC");

  // No byte is taken while a multi-beat reply is still being sent.
  a_hold_input : assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tlast |-> !in_tready)
    else $error("input taken during reply");

endmodule

// ===== hw/rtl/tnrop_parse.sv =====
// Byte parser: tracks the command phase and option states and describes the results of each byte.
module tnrop_parse (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                accept,
  input  logic [7:0]          rx_byte,
  input  logic                termtype_allowed,
  input  logic                echo_allowed,
  input  logic                suppress_ga_allowed,
  output tnrop_pkg::desc_t    desc
);

  tnrop_pkg::phase_t phase_r, phase_nxt;
  logic [1:0]        verb_r, verb_nxt;
  logic              termtype_on_r, termtype_on_nxt;
  logic              echo_on_r, echo_on_nxt;
  logic              sga_on_r, sga_on_nxt;

  always_comb begin
    phase_nxt       = phase_r;
    verb_nxt        = verb_r;
    termtype_on_nxt = termtype_on_r;
    echo_on_nxt     = echo_on_r;
    sga_on_nxt      = sga_on_r;
    desc.kind       = tnrop_pkg::K_NONE;
    desc.b0         = rx_byte;
    desc.b1         = rx_byte;
    unique case (phase_r)
      tnrop_pkg::PH_DATA: begin
        if (rx_byte == tnrop_pkg::B_IAC) begin
          phase_nxt = tnrop_pkg::PH_IAC;
        end else begin
          desc.kind = tnrop_pkg::K_DATA;
        end
      end
      tnrop_pkg::PH_IAC: begin
        phase_nxt = tnrop_pkg::PH_DATA;
        if (rx_byte == tnrop_pkg::B_IAC) begin
          desc.kind = tnrop_pkg::K_DATA;
        end else if (rx_byte == tnrop_pkg::B_SB) begin
          phase_nxt = tnrop_pkg::PH_SB_OPT;
        end else if (rx_byte >= tnrop_pkg::B_WILL && rx_byte <= tnrop_pkg::B_DONT) begin
          verb_nxt  = 2'(rx_byte - tnrop_pkg::B_WILL);
          phase_nxt = tnrop_pkg::PH_OPT;
        end
      end
      tnrop_pkg::PH_OPT: begin
        phase_nxt = tnrop_pkg::PH_DATA;
        if (verb_r == tnrop_pkg::VERB_DO) begin
          if (rx_byte == tnrop_pkg::OPT_TT) begin
            if (!termtype_on_r) begin
              desc.kind = tnrop_pkg::K_REPLY3;
              if (termtype_allowed) begin
                termtype_on_nxt = 1'b1;
                desc.b0         = tnrop_pkg::B_WILL;
              end else begin
                desc.b0 = tnrop_pkg::B_WONT;
              end
            end
          end else begin
            desc.kind = tnrop_pkg::K_REPLY3;
            desc.b0   = tnrop_pkg::B_WONT;
          end
        end else if (verb_r == tnrop_pkg::VERB_WILL) begin
          if (rx_byte == tnrop_pkg::OPTION_ECHO) begin
            if (!echo_on_r) begin
              desc.kind = tnrop_pkg::K_REPLY3;
              if (echo_allowed) begin
                echo_on_nxt = 1'b1;
                desc.b0     = tnrop_pkg::B_DO;
              end else begin
                desc.b0 = tnrop_pkg::B_DONT;
              end
            end
          end else if (rx_byte == tnrop_pkg::OPT_SGA) begin
            if (!sga_on_r) begin
              desc.kind = tnrop_pkg::K_REPLY3;
              if (suppress_ga_allowed) begin
                sga_on_nxt = 1'b1;
                desc.b0    = tnrop_pkg::B_DO;
              end else begin
                desc.b0 = tnrop_pkg::B_DONT;
              end
            end
          end else begin
            desc.kind = tnrop_pkg::K_REPLY3;
            desc.b0   = tnrop_pkg::B_DONT;
          end
        end
      end
      tnrop_pkg::PH_SB_OPT: begin
        phase_nxt = (rx_byte == tnrop_pkg::OPT_TT) ? tnrop_pkg::PH_SB_CMD : tnrop_pkg::PH_SKIP;
      end
      tnrop_pkg::PH_SB_CMD: begin
        phase_nxt = tnrop_pkg::PH_SKIP;
        if (rx_byte == tnrop_pkg::TT_SEND) begin
          desc.kind = tnrop_pkg::K_TTSEND;
        end
      end
      tnrop_pkg::PH_SKIP: begin
        if (rx_byte == tnrop_pkg::B_IAC) begin
          phase_nxt = tnrop_pkg::PH_SKIP_IAC;
        end
      end
      tnrop_pkg::PH_SKIP_IAC: begin
        phase_nxt = (rx_byte == tnrop_pkg::B_IAC) ? tnrop_pkg::PH_SKIP : tnrop_pkg::PH_DATA;
      end
      default: begin
        phase_nxt = tnrop_pkg::PH_DATA;
      end
    endcase
    desc.echo = echo_on_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= tnrop_pkg::PH_DATA;
      verb_r        <= 2'd0;
      termtype_on_r <= 1'b0;
      echo_on_r     <= 1'b0;
      sga_on_r      <= 1'b0;
    end else if (accept) begin
      phase_r       <= phase_nxt;
      verb_r        <= verb_nxt;
      termtype_on_r <= termtype_on_nxt;
      echo_on_r     <= echo_on_nxt;
      sga_on_r      <= sga_on_nxt;
    end
  end

endmodule

// ===== hw/rtl/tnrop_emit.sv =====
// Result register and beat sequencer that sends out the bytes of one described request.
module tnrop_emit #(
  parameter int NAME_BYTES = 8
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    load,
  input  tnrop_pkg::desc_t        desc,
  input  logic [NAME_BYTES*8-1:0] term_name,
  input  logic [3:0]              term_name_length,
  output logic                    can_load,
  output logic                    out_tvalid,
  input  logic                    out_tready,
  output logic [15:0]             out_tdata,
  output logic                    out_tuser,
  output logic                    out_tlast
);

  localparam logic [3:0] NB = 4'(NAME_BYTES);

  tnrop_pkg::desc_t desc_r;
  logic             valid_r;
  logic [3:0]       idx_r;
  logic [3:0]       len_eff;
  logic [3:0]       name_cnt;
  logic [2:0]       ni;
  logic [63:0]      name_ext;
  logic [7:0]       name_byte;
  logic [7:0]       byte_o;
  logic             last_o;

  always_comb begin
    len_eff   = (term_name_length > NB) ? NB : term_name_length;
    name_cnt  = (len_eff == 4'd0) ? tnrop_pkg::UNKNOWN_LEN : len_eff;
    ni        = idx_r[2:0] - 3'd4;
    name_ext  = 64'(term_name);
    name_byte = (len_eff == 4'd0) ? tnrop_pkg::unknown_char(ni)
                                  : name_ext[{ni, 3'b000} +: 8];
    byte_o    = desc_r.b0;
    last_o    = 1'b1;
    unique case (desc_r.kind)
      tnrop_pkg::K_REPLY3: begin
        last_o = (idx_r == 4'd2);
        priority if (idx_r == 4'd0) begin
          byte_o = tnrop_pkg::B_IAC;
        end else if (idx_r == 4'd1) begin
          byte_o = desc_r.b0;
        end else begin
          byte_o = desc_r.b1;
        end
      end
      tnrop_pkg::K_TTSEND: begin
        last_o = (idx_r == name_cnt + 4'd5);
        priority if (idx_r == 4'd0) begin
          byte_o = tnrop_pkg::B_IAC;
        end else if (idx_r == 4'd1) begin
          byte_o = tnrop_pkg::B_SB;
        end else if (idx_r == 4'd2) begin
          byte_o = tnrop_pkg::OPT_TT;
        end else if (idx_r == 4'd3) begin
          byte_o = tnrop_pkg::TT_IS;
        end else if (idx_r < name_cnt + 4'd4) begin
          byte_o = name_byte;
        end else if (idx_r == name_cnt + 4'd4) begin
          byte_o = tnrop_pkg::B_IAC;
        end else begin
          byte_o = tnrop_pkg::B_SE;
        end
      end
      default: begin
        byte_o = desc_r.b0;
        last_o = 1'b1;
      end
    endcase
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = {7'd0, desc_r.echo, byte_o};
  assign out_tuser  = (desc_r.kind != tnrop_pkg::K_DATA);
  assign out_tlast  = last_o;
  assign can_load   = !valid_r || (out_tready && last_o);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      idx_r   <= 4'd0;
    end else if (load && desc.kind != tnrop_pkg::K_NONE) begin
      valid_r <= 1'b1;
      idx_r   <= 4'd0;
    end else if (valid_r && out_tready) begin
      if (last_o) begin
        valid_r <= 1'b0;
      end else begin
        idx_r <= idx_r + 4'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load && desc.kind != tnrop_pkg::K_NONE) begin
      desc_r <= desc;
    end
  end

endmodule
